>>> sv/sgb_pkg.sv
// ----------------------------------------------------------------------------
// sgb_pkg
// Shared types and constants of the scanline gap bridger: phase codes, the
// emit request passed from the classifier to the emitter, and queue sizing.
// ----------------------------------------------------------------------------
`default_nettype none

package sgb_pkg;

	// width of held-run counts and of the bridged length field
	localparam int CNT_W = 6;

	// default and bound for the gap limit
	localparam int MAX_GAP_LIMIT_DEF = 32;

	// request queue between classifier and emitter
	localparam int Q_AW    = 2;
	localparam int Q_DEPTH = 1 << Q_AW;

	// tdata widths, whole bytes
	localparam int S_DATA_W = 8;
	localparam int M_DATA_W = 8;

	// scan phase of the classifier
	typedef enum logic [1:0] {
		PH_IDLE = 2'd0,
		PH_RUN  = 2'd1,
		PH_GAP  = 2'd2
	} phase_t;

	// one emit request: count held pixels, then the closing pixel
	typedef struct packed {
		logic [CNT_W-1:0] count;  // held empty pixels to emit first
		logic             fill;   // held pixels are bridged
		logic             sup;    // support of the closing pixel
		logic             re;     // closing pixel ends the row
	} cmd_t;

endpackage

`default_nettype wire

>>> sv/sgb_front.sv
// ----------------------------------------------------------------------------
// sgb_front
// Pixel classifier: tracks the scan phase and the held empty run, and turns
// each pixel that does not join a held run into one request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_front
	import sgb_pkg::*;
#(
	parameter int MAX_GAP_LIMIT = MAX_GAP_LIMIT_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	// gap limit register write
	input  wire logic             cfg_valid,
	input  wire logic [CNT_W-1:0] cfg_data,
	// pixel input
	input  wire logic             in_valid,
	input  wire logic             in_support,
	input  wire logic             in_model,
	input  wire logic             in_re,
	output logic                  in_ready,
	// emit requests
	input  wire logic             q_full,
	output logic                  push,
	output cmd_t                  cmd
);

	localparam logic [CNT_W-1:0] LIMIT = CNT_W'(MAX_GAP_LIMIT);

	phase_t           phase_q, phase_d;
	logic [CNT_W-1:0] max_gap_q;
	logic [CNT_W-1:0] held_q, held_d;
	logic             mig_q, mig_d;
	logic [CNT_W-1:0] eff;
	logic [CNT_W:0]   cnt_next;
	logic             accept;
	logic             fill;

	// gap limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_gap_q <= '0;
		end else if (cfg_valid) begin
			max_gap_q <= cfg_data;
		end
	end

	// effective limit saturates at the build-time bound
	assign eff      = (max_gap_q > LIMIT) ? LIMIT : max_gap_q;
	assign cnt_next = {1'b0, held_q} + {{CNT_W{1'b0}}, 1'b1};
	assign fill     = !mig_q && (held_q != '0) && (held_q <= eff);

	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;

	// phase register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			held_q  <= '0;
			mig_q   <= 1'b0;
		end else begin
			phase_q <= phase_d;
			held_q  <= held_d;
			mig_q   <= mig_d;
		end
	end

	// classification and next phase
	always_comb begin
		phase_d   = phase_q;
		held_d    = held_q;
		mig_d     = mig_q;
		push      = 1'b0;
		cmd.count = '0;
		cmd.fill  = 1'b0;
		cmd.sup   = in_support;
		cmd.re    = in_re;
		if (accept) begin
			case (phase_q)
				PH_GAP: begin
					if (in_support) begin
						push      = 1'b1;
						cmd.count = held_q;
						cmd.fill  = fill;
						phase_d   = PH_RUN;
						held_d    = '0;
						mig_d     = 1'b0;
					end else if ((cnt_next > {1'b0, eff}) || in_re) begin
						// run too long or open at row end: flush unchanged
						push      = 1'b1;
						cmd.count = held_q;
						phase_d   = PH_IDLE;
						held_d    = '0;
						mig_d     = 1'b0;
					end else begin
						held_d = cnt_next[CNT_W-1:0];
						mig_d  = mig_q || in_model;
					end
				end
				PH_RUN: begin
					if (in_support) begin
						push = 1'b1;
					end else if ((eff == '0) || in_re) begin
						push    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						phase_d = PH_GAP;
						held_d  = {{(CNT_W-1){1'b0}}, 1'b1};
						mig_d   = in_model;
					end
				end
				default: begin
					push    = 1'b1;
					phase_d = in_support ? PH_RUN : PH_IDLE;
				end
			endcase
			// every row end returns to idle
			if (in_re) begin
				phase_d = PH_IDLE;
				held_d  = '0;
				mig_d   = 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

>>> sv/sgb_queue.sv
// ----------------------------------------------------------------------------
// sgb_queue
// Short request queue between classifier and emitter, so that each side can
// stall on its own.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_queue
	import sgb_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire cmd_t push_cmd,
	input  wire logic pop,
	output logic      full,
	output logic      head_valid,
	output cmd_t      head
);

	cmd_t            mem [Q_DEPTH];
	logic [Q_AW-1:0] wr_ptr_q;
	logic [Q_AW-1:0] rd_ptr_q;
	logic [Q_AW:0]   fill_q;
	logic            do_push;
	logic            do_pop;

	assign full       = (fill_q == (Q_AW+1)'(Q_DEPTH));
	assign head_valid = (fill_q != '0);
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;
	assign head       = mem[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10:   fill_q <= fill_q + 1'b1;
				2'b01:   fill_q <= fill_q - 1'b1;
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

`default_nettype wire

>>> sv/sgb_back.sv
// ----------------------------------------------------------------------------
// sgb_back
// Pixel emitter: expands each request into its held pixels and the closing
// pixel, one per cycle while out_ready holds, via a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module sgb_back
	import sgb_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	// request queue head
	input  wire logic             head_valid,
	input  wire cmd_t             head,
	output logic                  pop,
	// pixel output
	output logic                  out_valid,
	input  wire logic             out_ready,
	output logic                  out_support,
	output logic                  out_added,
	output logic [CNT_W-1:0]      out_len,
	output logic                  out_re,
	output logic                  out_last
);

	logic             valid_q;
	logic             sup_q;
	logic             added_q;
	logic [CNT_W-1:0] len_q;
	logic             re_q;
	logic             last_q;
	logic [CNT_W-1:0] idx_q;
	logic             load;
	logic             closing;

	assign load    = head_valid && (!valid_q || out_ready);
	assign closing = (idx_q == head.count);
	assign pop     = load && closing;

	// emit counter within the current request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= closing ? '0 : idx_q + 1'b1;
			end
			if (load) begin
				valid_q <= 1'b1;
			end else if (out_ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	// output payload
	always_ff @(posedge clk) begin
		if (load) begin
			if (closing) begin
				sup_q   <= head.sup;
				added_q <= 1'b0;
				len_q   <= head.fill ? head.count : '0;
				re_q    <= head.re;
				last_q  <= 1'b1;
			end else begin
				sup_q   <= head.fill;
				added_q <= head.fill;
				len_q   <= '0;
				re_q    <= 1'b0;
				last_q  <= 1'b0;
			end
		end
	end

	assign out_valid   = valid_q;
	assign out_support = sup_q;
	assign out_added   = added_q;
	assign out_len     = len_q;
	assign out_re      = re_q;
	assign out_last    = last_q;

	// a filled pixel always shows support
	a_added_sup: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && added_q |-> sup_q)
		else $error("added pixel without support");

	// a bridged length appears only on a closing support pixel
	a_len_close: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && (len_q != '0) |-> last_q && sup_q && !added_q)
		else $error("bridge length on a non-closing pixel");

	// the counter never runs past the request
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> idx_q <= head.count)
		else $error("emit counter beyond request length");

	// after a request retires the next one starts from its first pixel
	a_pop_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0)
		else $error("emit counter not restarted after retire");

endmodule

`default_nettype wire

>>> sv/scanline_gap_bridger.sv
// ----------------------------------------------------------------------------
// scanline_gap_bridger
// Bridges short empty runs after support runs in a scan-ordered raster.
// ----------------------------------------------------------------------------
// A pixel request is taken whenever the four-entry request queue has room;
// pixels that join a held gap push no request until the hold ends. Every
// input pixel leaves exactly once and in order, one output pixel a cycle
// while the receiver is ready, so the sustained rate is one pixel per cycle.
// A gap of n held pixels is released as n+1 output pixels by the emitter
// counter, while the queue lets the front keep taking pixels. max_gap is
// written through the cfg channel (always ready) and saturates at
// MAX_GAP_LIMIT; zero passes pixels through unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module scanline_gap_bridger
	import sgb_pkg::*;
#(
	parameter int MAX_GAP_LIMIT = MAX_GAP_LIMIT_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// gap limit register
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire logic [CNT_W-1:0]    cfg_data,     // max_gap
	// pixel input
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [S_DATA_W-1:0] s_tdata,      // [0] support_bit, [1] model_bit
	input  wire logic                s_tlast,      // row_end
	// pixel output
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,      // [0] out_support, [1] added,
	                                               // [7:2] bridge_len
	output logic                     m_tlast,      // row_end_out
	output logic                     m_tuser       // last
);

	logic             q_full;
	logic             push;
	cmd_t             push_cmd;
	logic             head_valid;
	cmd_t             head;
	logic             pop;
	logic             o_sup;
	logic             o_added;
	logic [CNT_W-1:0] o_len;

	assign cfg_ready = 1'b1;

	// classifier
	sgb_front #(
		.MAX_GAP_LIMIT(MAX_GAP_LIMIT)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.in_valid   (s_tvalid),
		.in_support (s_tdata[0]),
		.in_model   (s_tdata[1]),
		.in_re      (s_tlast),
		.in_ready   (s_tready),
		.q_full     (q_full),
		.push       (push),
		.cmd        (push_cmd)
	);

	// request queue
	sgb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.pop        (pop),
		.full       (q_full),
		.head_valid (head_valid),
		.head       (head)
	);

	// emitter
	sgb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head        (head),
		.pop         (pop),
		.out_valid   (m_tvalid),
		.out_ready   (m_tready),
		.out_support (o_sup),
		.out_added   (o_added),
		.out_len     (o_len),
		.out_re      (m_tlast),
		.out_last    (m_tuser)
	);

	// output packing
	assign m_tdata = {o_len, o_added, o_sup};

endmodule

`default_nettype wire

>>> verif/tb_scanline_gap_bridger.sv
// ----------------------------------------------------------------------------
// tb_scanline_gap_bridger
// Self-checking bench for the scanline gap bridger. Pixel requests are fed from
// a queue by a bursty driver; every accepted pixel runs through a bit-exact
// predictor of the bridging rules, and each output pixel is checked field by
// field against the oldest predicted pixel while the receiver stalls at random.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_scanline_gap_bridger
	import sgb_pkg::*;
();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STUCK_LIMIT = 2000;
	localparam int SETTLE_CYC  = 8;
	localparam int HOLD_CYC    = 240;

	// one input pixel
	typedef struct {
		bit sup;
		bit mdl;
		bit re;
	} pix_t;

	// one output pixel as it should leave the block
	typedef struct {
		logic             sup;
		logic             added;
		logic [CNT_W-1:0] len;
		logic             re;
		logic             last;
	} out_pix_t;

	logic                clk;
	logic                arst_n    = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [CNT_W-1:0]    cfg_data  = '0;
	logic                s_tvalid  = 1'b0;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata   = '0;   // [0] support_bit, [1] model_bit
	logic                s_tlast   = 1'b0; // row_end
	logic                m_tvalid;
	logic                m_tready  = 1'b0;
	logic [M_DATA_W-1:0] m_tdata;          // [0] out_support, [1] added, [7:2] bridge_len
	logic                m_tlast;          // row_end_out
	logic                m_tuser;          // last

	// pixel stream still to be offered, and pixels expected out of the block
	pix_t     pend_q[$];
	out_pix_t emitted_q[$];
	pix_t     cur_pix;
	out_pix_t want_pix;

	// mirror of the bridging state
	logic [CNT_W-1:0] gap_limit  = '0;
	phase_t           scan_phase = PH_IDLE;
	int unsigned      held_len   = 0;
	bit               held_model = 1'b0;

	int n_err       = 0;
	int n_queued    = 0;
	int burst_left  = 0;
	int pause_left  = 0;
	int rx_cycle    = 0;
	int rx_mode     = 0;
	int hold_left   = 0;
	int stuck_cycles = 0;
	bit squeeze      = 1'b0;
	bit squeeze_done = 1'b0;

	scanline_gap_bridger i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ------------------------------------------------------------------------
	// predictor
	// ------------------------------------------------------------------------

	function automatic void emit(bit s, bit a, int unsigned len, bit re, bit last);
		out_pix_t o;
		o.sup   = s;
		o.added = a;
		o.len   = CNT_W'(len);
		o.re    = re;
		o.last  = last;
		emitted_q = {emitted_q, o};
	endfunction

	// one pixel through the bridging rules
	function automatic void bridge_pixel(pix_t p);
		int unsigned lim;
		bit          fill;
		lim = (gap_limit > MAX_GAP_LIMIT_DEF) ? MAX_GAP_LIMIT_DEF : gap_limit;
		case (scan_phase)
			PH_GAP: begin
				if (p.sup) begin
					// closing support pixel, bridge if short and free of model
					fill = !held_model && held_len > 0 && held_len <= lim;
					repeat (held_len) emit(fill, fill, 0, 1'b0, 1'b0);
					emit(1'b1, 1'b0, fill ? held_len : 0, p.re, 1'b1);
					scan_phase = PH_RUN;
					held_len   = 0;
					held_model = 1'b0;
				end else if (held_len + 1 > lim || p.re) begin
					// run too long or open at row end, flush unchanged
					repeat (held_len) emit(1'b0, 1'b0, 0, 1'b0, 1'b0);
					emit(1'b0, 1'b0, 0, p.re, 1'b1);
					scan_phase = PH_IDLE;
					held_len   = 0;
					held_model = 1'b0;
				end else begin
					held_len++;
					held_model = held_model | p.mdl;
				end
			end
			PH_RUN: begin
				if (p.sup) begin
					emit(1'b1, 1'b0, 0, p.re, 1'b1);
				end else if (lim < 1 || p.re) begin
					emit(1'b0, 1'b0, 0, p.re, 1'b1);
					scan_phase = PH_IDLE;
				end else begin
					scan_phase = PH_GAP;
					held_len   = 1;
					held_model = p.mdl;
				end
			end
			default: begin
				emit(p.sup, 1'b0, 0, p.re, 1'b1);
				scan_phase = p.sup ? PH_RUN : PH_IDLE;
			end
		endcase
		// every row end returns to idle
		if (p.re) begin
			scan_phase = PH_IDLE;
			held_len   = 0;
			held_model = 1'b0;
		end
	endfunction

	// ------------------------------------------------------------------------
	// pixel driver: bursts with random pauses
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata  <= '0;
			s_tlast  <= 1'b0;
		end else begin
			if (s_tvalid && s_tready)
				bridge_pixel(cur_pix);
			if (!s_tvalid || s_tready) begin
				if (pause_left > 0) begin
					pause_left--;
					s_tvalid <= 1'b0;
				end else if (pend_q.size() > 0) begin
					cur_pix = pend_q.pop_front();
					s_tvalid <= 1'b1;
					s_tdata  <= S_DATA_W'({cur_pix.mdl, cur_pix.sup});
					s_tlast  <= cur_pix.re;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						// next burst, sometimes with no pause in between
						burst_left = $urandom_range(0, 15);
						pause_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
					end
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// receiver stall pattern, with one long hold-off on request
	// ------------------------------------------------------------------------
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			rx_cycle++;
			if (squeeze && !squeeze_done) begin
				squeeze_done = 1'b1;
				hold_left    = HOLD_CYC;
			end
			if (rx_cycle % 32 == 0)
				rx_mode = $urandom_range(0, 3);
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				case (rx_mode)
					0:       m_tready <= 1'b1;
					1:       m_tready <= ($urandom_range(0, 3) != 0);
					2:       m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= rx_cycle[0];
				endcase
			end
		end
	end

	// ------------------------------------------------------------------------
	// output check
	// ------------------------------------------------------------------------

	function automatic void check_field(string fname, logic [CNT_W-1:0] want,
			logic [CNT_W-1:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			n_err++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (emitted_q.size() == 0) begin
				$error("output pixel with none expected: tdata %h", m_tdata);
				n_err++;
			end else begin
				want_pix = emitted_q.pop_front();
				check_field("out_support", CNT_W'(want_pix.sup),   CNT_W'(m_tdata[0]));
				check_field("added",       CNT_W'(want_pix.added), CNT_W'(m_tdata[1]));
				check_field("bridge_len",  want_pix.len,           m_tdata[7:2]);
				check_field("row_end_out", CNT_W'(want_pix.re),    CNT_W'(m_tlast));
				check_field("last",        CNT_W'(want_pix.last),  CNT_W'(m_tuser));
			end
		end
	end

	// watchdog on cycles without any request moving
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)
				|| (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Testbench completed WITH ERRORS");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------

	task automatic add_pix(bit s, bit m, bit r);
		pix_t p;
		p.sup = s;
		p.mdl = m;
		p.re  = r;
		pend_q = {pend_q, p};
		n_queued++;
	endtask

	// all requests taken and all output seen, then let held work settle
	task automatic wait_drained();
		do @(negedge clk);
		while (pend_q.size() != 0 || s_tvalid || emitted_q.size() != 0);
		repeat (SETTLE_CYC) @(negedge clk);
	endtask

	task automatic set_gap_limit(logic [CNT_W-1:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk);
		while (!cfg_ready);
		gap_limit = v;
		cfg_valid <= 1'b0;
	endtask

	// a support run and a gap of chosen length, or a few noise pixels
	task automatic add_segment(int lim);
		int gap_n;
		int mdl_at;
		int k;
		if ($urandom_range(0, 4) == 0) begin
			repeat ($urandom_range(1, 6))
				add_pix(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					$urandom_range(0, 7) == 0);
		end else begin
			repeat ($urandom_range(1, 3))
				add_pix(1'b1, $urandom_range(0, 3) == 0, 1'b0);
			// long gaps at the limit only now and then for big limits
			case ($urandom_range(0, (lim > 8) ? 11 : 5))
				0:       gap_n = lim;
				1:       gap_n = lim + 1;
				2:       gap_n = $urandom_range(1, lim + 2);
				default: gap_n = $urandom_range(1, 3);
			endcase
			if (gap_n < 1)
				gap_n = 1;
			mdl_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, gap_n - 1) : -1;
			for (k = 0; k < gap_n; k++)
				add_pix(1'b0, k == mdl_at, 1'b0);
			case ($urandom_range(0, 5))
				0:       add_pix(1'b0, 1'($urandom_range(0, 1)), 1'b1);
				1:       add_pix(1'b1, 1'b0, 1'b1);
				default: add_pix(1'b1, 1'($urandom_range(0, 1)), 1'b0);
			endcase
		end
	endtask

	task automatic run_phase(logic [CNT_W-1:0] limit, int n_pix);
		int first;
		int lim;
		set_gap_limit(limit);
		lim   = (limit > MAX_GAP_LIMIT_DEF) ? MAX_GAP_LIMIT_DEF : limit;
		first = n_queued;
		while (n_queued - first < n_pix)
			add_segment(lim);
		wait_drained();
	endtask

	initial begin
		logic [CNT_W-1:0] limits[9];
		limits = '{6'd2, 6'd0, 6'd5, 6'd32, 6'd63, 6'd1, 6'd17, 6'd33, 6'd0};
		limits[8] = CNT_W'($urandom_range(0, 63));

		arst_n = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		// zero limit out of reset: plain pass-through
		add_pix(1'b1, 1'b0, 1'b0);
		add_pix(1'b0, 1'b1, 1'b0);
		add_pix(1'b1, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b1);
		wait_drained();

		set_gap_limit(6'd3);
		// short gap bridged
		add_pix(1'b1, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b1, 1'b0, 1'b0);
		// model pixel in the gap blocks the bridge
		add_pix(1'b0, 1'b1, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b1, 1'b0, 1'b0);
		// run too long, flushed on the fourth pixel, then pass-through
		repeat (5) add_pix(1'b0, 1'b0, 1'b0);
		// open gap at row end
		add_pix(1'b1, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b1);
		// gap closed on the row end pixel
		add_pix(1'b1, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b1, 1'b0, 1'b1);
		// leave two pixels held across the limit change
		add_pix(1'b1, 1'b1, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		add_pix(1'b0, 1'b0, 1'b0);
		wait_drained();

		// limit lowered while holding: the held pair must not be bridged
		set_gap_limit(6'd1);
		add_pix(1'b1, 1'b0, 1'b1);
		wait_drained();

		// random phases over several limits, long hold-off in the phase with limit 32
		for (int i = 0; i < 9; i++) begin
			if (limits[i] == 6'd32)
				squeeze = 1'b1;
			run_phase(limits[i], 34);
		end

		if (n_err == 0 && emitted_q.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
